[sv/i2da_pkg.sv]
// Shared types and constants for the integer-to-decimal-ASCII block.
// No dependencies; imported by every module of the block.
package i2da_pkg;

    // Width of the two's complement input word
    localparam int VALUE_BITS = 32;

    // Decimal digits needed for the largest magnitude: ceil(VALUE_BITS * log10(2))
    localparam int DIGITS    = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int DIG_IDX_W = $clog2(DIGITS);
    localparam int BCD_W     = DIGITS * 4;

    // Magnitude padded to an even width, converted two bits per cycle
    localparam int BIN_W      = VALUE_BITS + (VALUE_BITS % 2);
    localparam int STEPS      = BIN_W / 2;
    localparam int STEP_CNT_W = $clog2(STEPS + 1);

    // ASCII codes
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    // Shift-add-3 correction: a digit of five or more gets three added before the shift
    localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ       = 4'd3;

    // One classified number in the queue
    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } i2da_item_t;

endpackage

[sv/int_to_decimal_ascii_unit.sv]
// Top level of the integer-to-decimal-ASCII block.
// Instantiates i2da_front and i2da_back; depends on i2da_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready/s_value) takes one signed VALUE_BITS-bit
//   word per number. Output channel (m_valid/m_ready/m_character/
//   m_last_char) gives its decimal text, one ASCII word per transfer, most
//   significant first: '-' for negatives, no leading zeros, a lone '0' for
//   zero. m_last_char marks the final word of each number.
//   Conversion runs in the two-bit-per-cycle shift-add-3 BCD converter, and
//   the output register gives one word per cycle while the receiver is ready;
//   each number yields 1 to 11 words at 32 bits. The back end takes a new
//   number only once the last word of the previous one is in the output
//   register.
//   A two-entry queue in front lets up to two numbers be accepted while an
//   earlier one is still converting or emitting.
//   When the receiver stalls, the output register holds its word and the
//   back end waits; the queue keeps taking input until full.
//   Reset (aresetn low, synchronous) empties the queue, drops any number in
//   progress and clears m_valid.
module int_to_decimal_ascii_unit
    import i2da_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_character,
    output logic                         m_last_char
);

    logic       q_valid;
    logic       q_ready;
    i2da_item_t q_item;

    // Accept and classify
    i2da_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_value (s_value),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // Convert and emit
    i2da_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last_char (m_last_char)
    );

endmodule

[sv/i2da_front.sv]
// Front end: accepts input words, splits sign and unsigned magnitude,
// and holds them in a two-entry queue. Depends on i2da_pkg.
module i2da_front
    import i2da_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_value,
    output logic                         q_valid,
    input  logic                         q_ready,
    output i2da_item_t                   q_item
);

    i2da_item_t  mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;
    i2da_item_t  item_in;

    // Classify: magnitude as unsigned, so the most negative value works
    always_comb begin
        item_in.neg = s_value[VALUE_BITS-1];
        item_in.mag = item_in.neg ? (~s_value + 1'b1) : s_value;
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

[sv/i2da_back.sv]
// Back end: converts a magnitude to BCD (shift-add-3, two bits per cycle)
// and emits sign and digits as ASCII words. Depends on i2da_pkg.
module i2da_back
    import i2da_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  i2da_item_t q_item,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_character,
    output logic       m_last_char
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_LEAD = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [STEP_CNT_W-1:0]       step_reg, step_next;
    logic [BIN_W-1:0]            bin_reg, bin_next;
    logic [DIGITS-1:0][3:0]      bcd_reg, bcd_next;
    logic                        sign_pend_reg, sign_pend_next;
    logic [DIG_IDX_W-1:0]        dig_idx_reg, dig_idx_next;
    logic [DIG_IDX_W-1:0]        lead_idx;
    logic                        m_valid_reg, m_valid_next;
    logic [7:0]                  m_char_reg, m_char_next;
    logic                        m_last_reg, m_last_next;
    logic [BCD_W-1:0]            bcd_step;
    logic [BIN_W-1:0]            bin_step;
    logic                        out_free;

    assign q_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_character = m_char_reg;
    assign m_last_char = m_last_reg;
    assign out_free    = !m_valid_reg || m_ready;

    // Two shift-add-3 iterations per cycle
    always_comb begin
        logic [DIGITS-1:0][3:0] b;
        logic [BCD_W-1:0]       flat;
        logic [BIN_W-1:0]       r;
        b = bcd_reg;
        r = bin_reg;
        for (int it = 0; it < 2; it++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (b[d] >= BCD_ADJ_LIMIT) begin
                    b[d] = b[d] + BCD_ADJ;
                end
            end
            flat = b;
            flat = {flat[BCD_W-2:0], r[BIN_W-1]};
            b    = flat;
            r    = {r[BIN_W-2:0], 1'b0};
        end
        bcd_step = b;
        bin_step = r;
    end

    // Highest nonzero digit; zero maps to the units digit
    always_comb begin
        lead_idx = '0;
        for (int d = 0; d < DIGITS; d++) begin
            if (bcd_reg[d] != 4'd0) begin
                lead_idx = DIG_IDX_W'(d);
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        sign_pend_next = sign_pend_reg;
        dig_idx_next   = dig_idx_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_char_next    = m_char_reg;
        m_last_next    = m_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    bin_next       = BIN_W'(q_item.mag);
                    bcd_next       = '0;
                    sign_pend_next = q_item.neg;
                    step_next      = STEP_CNT_W'(STEPS);
                    state_next     = ST_CONV;
                end
            end
            ST_CONV: begin
                bin_next  = bin_step;
                bcd_next  = bcd_step;
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_CNT_W'(1)) begin
                    state_next = ST_LEAD;
                end
            end
            ST_LEAD: begin
                dig_idx_next = lead_idx;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (sign_pend_reg) begin
                        m_char_next    = CHAR_MINUS;
                        m_last_next    = 1'b0;
                        sign_pend_next = 1'b0;
                    end else begin
                        m_char_next = CHAR_ZERO + {4'd0, bcd_reg[dig_idx_reg]};
                        m_last_next = (dig_idx_reg == '0);
                        if (dig_idx_reg == '0) begin
                            state_next = ST_IDLE;
                        end else begin
                            dig_idx_next = dig_idx_reg - 1'b1;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        step_reg      <= step_next;
        bin_reg       <= bin_next;
        bcd_reg       <= bcd_next;
        sign_pend_reg <= sign_pend_next;
        dig_idx_reg   <= dig_idx_next;
        m_char_reg    <= m_char_next;
        m_last_reg    <= m_last_next;
    end

endmodule

[bench/int_to_decimal_ascii_unit_chk.sv]
`timescale 1ns / 1ps
// Checker for int_to_decimal_ascii_unit: watches both channels and predicts the
// decimal ASCII text of every accepted number. It compares each output word in order.
// Depends on i2da_pkg for VALUE_BITS, DIGITS and the ASCII codes.
module int_to_decimal_ascii_unit_chk
    import i2da_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_value,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [7:0]                   m_character,
    input  logic                         m_last_char,
    output int                           fail_count,
    output int                           words_pending
);

    localparam logic [VALUE_BITS-1:0] RADIX = 10;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } ascii_word_t;

    // Text still owed by the block, oldest word first
    ascii_word_t text_owed[$];
    int          mismatches;

    // Queue up the decimal text of one number: sign, then digits without leading zeros
    function automatic void predict_text(input logic [VALUE_BITS-1:0] number);
        logic [VALUE_BITS-1:0] mag;
        logic [7:0]            digit_codes [DIGITS];
        int                    n;
        mag = number;
        n   = 0;
        // magnitude as unsigned, so the most negative value needs no special path
        if (number[VALUE_BITS-1])
            mag = ~number + 1'b1;
        if (mag == '0) begin
            text_owed.push_back('{code: CHAR_ZERO, last: 1'b1});
        end else begin
            while (mag != '0) begin
                digit_codes[n] = CHAR_ZERO + 8'(mag % RADIX);
                mag = mag / RADIX;
                n++;
            end
            if (number[VALUE_BITS-1])
                text_owed.push_back('{code: CHAR_MINUS, last: 1'b0});
            for (int k = n - 1; k >= 0; k--)
                text_owed.push_back('{code: digit_codes[k], last: (k == 0)});
        end
    endfunction

    // Compare each output word with the oldest owed one, then log new input words
    always @(posedge aclk) begin
        ascii_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (text_owed.size() == 0) begin
                    $error("unexpected output word: character %0d, last_char %0b",
                           m_character, m_last_char);
                    mismatches++;
                end else begin
                    want = text_owed.pop_front();
                    if (m_character !== want.code) begin
                        $error("character: expected %0d, got %0d", want.code, m_character);
                        mismatches++;
                    end
                    if (m_last_char !== want.last) begin
                        $error("last_char: expected %0b, got %0b", want.last, m_last_char);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                predict_text(s_value);
        end
        fail_count    <= mismatches;
        words_pending <= text_owed.size();
    end

endmodule

[bench/int_to_decimal_ascii_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench top for int_to_decimal_ascii_unit: clock, reset, number stimulus and verdict.
// Depends on i2da_pkg, the block itself and int_to_decimal_ascii_unit_chk.
module int_to_decimal_ascii_unit_tb;
    import i2da_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 150;
    localparam int TAIL_CYCLES = 2 * (STEPS + 16);
    localparam int PHASE_ITEMS = 58;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [VALUE_BITS-1:0] s_value;
    logic                         m_valid;
    logic                         m_ready;
    logic [7:0]                   m_character;
    logic                         m_last_char;
    int                           fail_count;
    int                           words_pending;

    int  send_idle_pct;
    int  stall_pct;
    bit  hold_request;
    int  hold_left;
    int  cycle_count;

    logic signed [VALUE_BITS-1:0] corner_values[$];

    int_to_decimal_ascii_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last_char (m_last_char)
    );

    int_to_decimal_ascii_unit_chk i_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_character   (m_character),
        .m_last_char   (m_last_char),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("int_to_decimal_ascii_unit test failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Random number: full range, small values, powers of ten and near the extremes
    function automatic logic [VALUE_BITS-1:0] random_number();
        logic [VALUE_BITS-1:0] w;
        longint unsigned       p;
        int                    pick;
        pick = $urandom_range(0, 9);
        p    = 1;
        if (pick <= 3) begin
            w = VALUE_BITS'({$urandom, $urandom});
        end else if (pick <= 6) begin
            w = VALUE_BITS'($urandom_range(0, 999));
        end else if (pick <= 8) begin
            repeat ($urandom_range(0, 9)) p = p * 10;
            w = VALUE_BITS'(p) - VALUE_BITS'($urandom_range(0, 1));
        end else begin
            w = {1'b0, {(VALUE_BITS-1){1'b1}}} - VALUE_BITS'($urandom_range(0, 3));
        end
        if (pick >= 4 && $urandom_range(0, 1))
            w = ~w + 1'b1;
        return w;
    endfunction

    // Offer one number after an optional gap, return once it is accepted
    task automatic send_number(input logic [VALUE_BITS-1:0] number);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            s_value <= VALUE_BITS'({$urandom, $urandom});
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= number;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop offering and wait until every owed word has come out
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (words_pending != 0) @(posedge aclk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (PHASE_ITEMS) send_number(random_number());
        wait_for_drain();
    endtask

    initial begin
        s_valid       = 1'b0;
        s_value       = '0;
        m_ready       = 1'b0;
        aresetn       = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 1'b0;
        hold_left     = 0;
        cycle_count   = 0;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: zero, single digits, digit-count boundaries, both extremes
        corner_values.push_back(0);
        corner_values.push_back(1);
        corner_values.push_back(-1);
        corner_values.push_back(9);
        corner_values.push_back(10);
        corner_values.push_back(-10);
        corner_values.push_back(99);
        corner_values.push_back(-100);
        corner_values.push_back(999999999);
        corner_values.push_back(1000000000);
        corner_values.push_back(-999999999);
        corner_values.push_back(-1000000000);
        corner_values.push_back(1234567890);
        corner_values.push_back(-1234567890);
        corner_values.push_back({1'b0, {(VALUE_BITS-1){1'b1}}});
        corner_values.push_back({1'b1, {(VALUE_BITS-1){1'b0}}});
        corner_values.push_back({1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1});
        corner_values.push_back({(VALUE_BITS/2){2'b01}});
        corner_values.push_back({(VALUE_BITS/2){2'b10}});
        corner_values.push_back(7);
        corner_values.push_back(-5);
        foreach (corner_values[i]) send_number(corner_values[i]);
        wait_for_drain();

        // Long receiver hold-off while numbers keep coming, so the input backs up
        hold_request = 1'b1;
        repeat (12) send_number(random_number());
        wait_for_drain();

        run_phase(0, 0);
        run_phase(55, 0);
        run_phase(0, 55);
        run_phase(25, 25);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && words_pending == 0)
            $display("int_to_decimal_ascii_unit test passed");
        else
            $display("int_to_decimal_ascii_unit test failed");
        $finish;
    end

endmodule

[filelist.f]
sv/i2da_pkg.sv
sv/i2da_front.sv
sv/i2da_back.sv
sv/int_to_decimal_ascii_unit.sv
bench/int_to_decimal_ascii_unit_chk.sv
bench/int_to_decimal_ascii_unit_tb.sv
